### src/sorted_array_priority_queue_core_macros.svh
// Assertion macros shared by the priority queue RTL.
// No dependencies; included by the files that carry assertions.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SAPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/sapq_pkg.sv
// Shared constants, codes and types of the sorted-array priority queue.
// No dependencies; imported by the cell and the top level.
package sapq_pkg;

	// Queue geometry.
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Field widths of the request and result words.
	localparam int REQ_W     = 3;
	localparam int DATA_W    = 16;
	localparam int PRIO_W    = 8;
	localparam int SLOT_W    = 6;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 7;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 72;
	localparam int M_USED_W  = STATUS_W + 2 * DATA_W + 2 * PRIO_W + SLOT_W + COUNT_W + 2;

	// Request codes.
	typedef enum logic [REQ_W-1:0] {
		REQ_ENQ  = 3'd0,
		REQ_DEQ  = 3'd1,
		REQ_UPD  = 3'd2,
		REQ_SRCH = 3'd3,
		REQ_READ = 3'd4
	} sapq_req_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_RANGE    = 3'd4
	} sapq_status_t;

	// What every cell of the row does in a cycle.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} sapq_cell_op_t;

	// Command broadcast to all cells.
	typedef struct packed {
		sapq_cell_op_t           op;
		logic [DATA_W-1:0]       data;
		logic [PRIO_W-1:0]       prio;
	} sapq_cell_cmd_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REINS
	} sapq_state_t;

endpackage

### src/sapq_cell.sv
// One slot of the sorted row: holds a data word and its priority.
// Depends on sapq_pkg; instantiated QUEUE_DEPTH times by the top level.
module sapq_cell
	import sapq_pkg::*;
(
	input  logic                  clk,
	input  sapq_cell_cmd_t        cmd,
	input  logic                  cell_valid,
	input  logic                  left_ins,
	input  logic [DATA_W-1:0]     left_data,
	input  logic [PRIO_W-1:0]     left_prio,
	input  logic [DATA_W-1:0]     right_data,
	input  logic [PRIO_W-1:0]     right_prio,
	input  logic                  rm_here,
	output logic                  ins_flag,
	output logic                  match,
	output logic [DATA_W-1:0]     data,
	output logic [PRIO_W-1:0]     prio,
	output logic [DATA_W-1:0]     nxt_data,
	output logic [PRIO_W-1:0]     nxt_prio
);

	logic [DATA_W-1:0] data_q;
	logic [PRIO_W-1:0] prio_q;

	// The new entry goes at or before this slot: slot empty or holds a larger priority.
	assign ins_flag = !cell_valid || (cmd.prio < prio_q);
	assign match    = cell_valid && (data_q == cmd.data);
	assign data     = data_q;
	assign prio     = prio_q;

	// Next content: keep, take the new entry, or shift from a neighbor.
	always_comb begin
		nxt_data = data_q;
		nxt_prio = prio_q;
		case (cmd.op)
			CELL_INSERT: begin
				if (ins_flag && !left_ins) begin
					nxt_data = cmd.data;
					nxt_prio = cmd.prio;
				end else if (ins_flag) begin
					nxt_data = left_data;
					nxt_prio = left_prio;
				end
			end
			CELL_REMOVE: begin
				if (rm_here) begin
					nxt_data = right_data;
					nxt_prio = right_prio;
				end
			end
			default: begin
			end
		endcase
	end

	// Slot storage; content is undefined until first written.
	always_ff @(posedge clk) begin
		data_q <= nxt_data;
		prio_q <= nxt_prio;
	end

endmodule

### src/sorted_array_priority_queue_core.sv
// Sorted-array priority queue: a row of compare-and-shift cells under a small sequencer.
// The request word is registered on acceptance; S_EXEC loads the result word once the output is
// free; an update that finds its data is removed in S_EXEC, then re-inserted and loaded in S_REINS.
// Requests are taken only in S_IDLE, after the last is through; the row shifts at most once per step.
// Reset clears the entry count, the sequencer and the output valid; the slots keep junk until written.
// Depends on sapq_pkg, sapq_cell and sorted_array_priority_queue_core_macros.svh.
`include "sorted_array_priority_queue_core_macros.svh"

module sorted_array_priority_queue_core
	import sapq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Request side.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// req_type[2:0], data_value[18:3], prio[26:19], slot_index[32:27], zero[39:33]
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// Result side.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status[2:0], out_data[18:3], out_priority[26:19], found_index[32:27],
	// head_data[48:33], head_priority[56:49], entry_count[63:57],
	// is_empty_flag[64], is_full_flag[65], zero[71:66]
	output logic [M_TDATA_W-1:0]  m_tdata
);

	sapq_state_t state_q, state_d;

	logic [REQ_W-1:0]     req_q;
	logic [DATA_W-1:0]    data_q;
	logic [PRIO_W-1:0]    prio_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [CNT_W-1:0]     count_q, count_d;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	sapq_cell_cmd_t       cmd;
	sapq_cell_op_t        cell_op;
	logic [IDX_W-1:0]     rm_from;
	logic                 out_load;
	logic [STATUS_W-1:0]  res_status;
	logic [DATA_W-1:0]    res_data;
	logic [PRIO_W-1:0]    res_prio;
	logic [SLOT_W-1:0]    res_found;
	logic [DATA_W-1:0]    head_data;
	logic [PRIO_W-1:0]    head_prio;

	logic [QUEUE_DEPTH-1:0] cell_valid, ins_flag, match, rm_here;
	logic [DATA_W-1:0]      cell_data [QUEUE_DEPTH];
	logic [PRIO_W-1:0]      cell_prio [QUEUE_DEPTH];
	logic [DATA_W-1:0]      nxt_data  [QUEUE_DEPTH];
	logic [PRIO_W-1:0]      nxt_prio  [QUEUE_DEPTH];

	logic                 found;
	logic [IDX_W-1:0]     where_idx;
	logic                 go;
	logic                 is_full, q_empty, slot_ok;

	assign cmd      = '{op: cell_op, data: data_q, prio: prio_q};
	assign go       = !m_tvalid_q || m_tready;
	assign is_full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_empty  = (count_q == '0);
	assign slot_ok  = (COUNT_W'(slot_q) < COUNT_W'(count_q));

	// Row of cells; each shifts from its left or right neighbor.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                 l_ins;
		logic [DATA_W-1:0]    l_data, r_data;
		logic [PRIO_W-1:0]    l_prio, r_prio;

		if (i == 0) begin : g_first
			assign l_ins  = 1'b0;
			assign l_data = cell_data[i];
			assign l_prio = cell_prio[i];
		end else begin : g_mid
			assign l_ins  = ins_flag[i-1];
			assign l_data = cell_data[i-1];
			assign l_prio = cell_prio[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign r_data = cell_data[i];
			assign r_prio = cell_prio[i];
		end else begin : g_inner
			assign r_data = cell_data[i+1];
			assign r_prio = cell_prio[i+1];
		end

		assign cell_valid[i] = (CNT_W'(i) < count_q);
		assign rm_here[i]    = (IDX_W'(i) >= rm_from);

		sapq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.cell_valid (cell_valid[i]),
			.left_ins   (l_ins),
			.left_data  (l_data),
			.left_prio  (l_prio),
			.right_data (r_data),
			.right_prio (r_prio),
			.rm_here    (rm_here[i]),
			.ins_flag   (ins_flag[i]),
			.match      (match[i]),
			.data       (cell_data[i]),
			.prio       (cell_prio[i]),
			.nxt_data   (nxt_data[i]),
			.nxt_prio   (nxt_prio[i])
		);
	end

	// First slot whose data matches the request.
	always_comb begin
		where_idx = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				where_idx = IDX_W'(i);
			end
		end
	end
	assign found = |match;

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (go) begin
					state_d = (req_q == REQ_UPD && found) ? S_REINS : S_IDLE;
				end
			end
			S_REINS: begin
				if (go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: row command, new count and result fields.
	always_comb begin
		s_tready   = 1'b0;
		cell_op    = CELL_HOLD;
		rm_from    = where_idx;
		out_load   = 1'b0;
		res_status = ST_OK;
		res_data   = '0;
		res_prio   = '0;
		res_found  = '0;
		count_d    = count_q;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
			end
			S_EXEC: begin
				if (go) begin
					out_load = 1'b1;
					case (req_q)
						REQ_ENQ: begin
							if (is_full) begin
								res_status = ST_FULL;
							end else begin
								cell_op = CELL_INSERT;
								count_d = count_q + 1'b1;
							end
						end
						REQ_DEQ: begin
							if (q_empty) begin
								res_status = ST_EMPTY;
							end else begin
								res_data = cell_data[0];
								res_prio = cell_prio[0];
								cell_op  = CELL_REMOVE;
								rm_from  = '0;
								count_d  = count_q - 1'b1;
							end
						end
						REQ_UPD: begin
							if (found) begin
								cell_op  = CELL_REMOVE;
								count_d  = count_q - 1'b1;
								out_load = 1'b0;
							end else begin
								res_status = ST_NOTFOUND;
							end
						end
						REQ_SRCH: begin
							if (found) begin
								res_found = SLOT_W'(where_idx);
							end else begin
								res_status = ST_NOTFOUND;
							end
						end
						REQ_READ: begin
							if (slot_ok) begin
								res_data = cell_data[slot_q[IDX_W-1:0]];
								res_prio = cell_prio[slot_q[IDX_W-1:0]];
							end else begin
								res_status = ST_RANGE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_REINS: begin
				if (go) begin
					cell_op  = CELL_INSERT;
					count_d  = count_q + 1'b1;
					out_load = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Head after the step comes from the first cell's next content.
	assign head_data = (count_d != '0) ? nxt_data[0] : '0;
	assign head_prio = (count_d != '0) ? nxt_prio[0] : '0;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request word capture and result word register.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q  <= s_tdata[REQ_W-1:0];
			data_q <= s_tdata[REQ_W +: DATA_W];
			prio_q <= s_tdata[REQ_W + DATA_W +: PRIO_W];
			slot_q <= s_tdata[REQ_W + DATA_W + PRIO_W +: SLOT_W];
		end
		if (out_load) begin
			m_tdata_q <= {
				(M_TDATA_W - M_USED_W)'(0),
				(count_d == CNT_W'(QUEUE_DEPTH)),
				(count_d == '0),
				COUNT_W'(count_d),
				head_prio,
				head_data,
				res_found,
				res_prio,
				res_data,
				res_status
			};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`SAPQ_ASSERT_NOW(a_count_max, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "count above depth")
	`SAPQ_ASSERT_NOW(a_head_sorted, clk, arst_n, count_q >= CNT_W'(2), cell_prio[0] <= cell_prio[1], "head out of order")
	`SAPQ_ASSERT_NEXT(a_idle_count, clk, arst_n, state_q == S_IDLE, count_q == $past(count_q), "count moved while idle")
	`SAPQ_ASSERT_NOW(a_reins_room, clk, arst_n, state_q == S_REINS, count_q < CNT_W'(QUEUE_DEPTH), "re-insert without room")

endmodule
